>>> design/ris_pkg.sv
// ----------------------------------------------------------------------------
// ris_pkg
// Shared types and constants for the rotated immediate splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ris_pkg;

	// Data-processing opcodes with special handling
	localparam logic [3:0] OP_TST = 4'h8;
	localparam logic [3:0] OP_TEQ = 4'h9;
	localparam logic [3:0] OP_ORR = 4'hc;
	localparam logic [3:0] OP_MOV = 4'hd;

	// Bits 27..25 of an immediate-form data-processing word
	localparam logic [2:0] IMM_FORM = 3'b001;

	localparam int MAX_WORDS  = 4;
	localparam int CNT_W      = $clog2(MAX_WORDS + 1);
	localparam int IDX_W      = $clog2(MAX_WORDS);
	localparam int NUM_STAGES = MAX_WORDS;

	// State of one item as it moves down the chunk pipeline
	typedef struct packed {
		logic [3:0]                  condition;
		logic                        set_flags;
		logic [3:0]                  opcode;
		logic [3:0]                  reg_number;
		logic [3:0]                  rn;
		logic [3:0]                  rd;
		logic [3:0]                  rot;
		logic [31:0]                 value;
		logic [CNT_W-1:0]            count;
		logic [MAX_WORDS-1:0][31:0]  words;
	} stage_t;

endpackage

`default_nettype wire

>>> design/ris_cmd_if.sv
// ----------------------------------------------------------------------------
// ris_cmd_if
// Input channel: one split request per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ris_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  condition;
	logic        set_flags;
	logic [3:0]  opcode;
	logic [3:0]  reg_number;
	logic [31:0] immediate;

	modport source (
		output valid, condition, set_flags, opcode, reg_number, immediate,
		input  ready
	);
	modport sink (
		input  valid, condition, set_flags, opcode, reg_number, immediate,
		output ready
	);
endinterface

`default_nettype wire

>>> design/ris_word_if.sv
// ----------------------------------------------------------------------------
// ris_word_if
// Output channel: one encoded instruction word per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ris_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] insn_word;
	logic        last;

	modport source (
		output valid, insn_word, last,
		input  ready
	);
	modport sink (
		input  valid, insn_word, last,
		output ready
	);
endinterface

`default_nettype wire

>>> design/ris_chunk_stage.sv
// ----------------------------------------------------------------------------
// ris_chunk_stage
// One pipeline stage: skip zero pairs, encode one word, consume a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ris_chunk_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire ris_pkg::stage_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ris_pkg::stage_t     out_data
);

	logic              valid_s1;
	ris_pkg::stage_t   data_s1;
	ris_pkg::stage_t   nxt;
	logic [3:0]        pair_idx;
	logic [31:0]       shifted;
	logic [3:0]        rot_adj;
	logic              emit;
	logic [31:0]       word;

	// lowest nonzero bit pair; zero when the value is zero
	always_comb begin
		pair_idx = '0;
		for (int i = 15; i >= 0; i--) begin
			if (in_data.value[2*i +: 2] != 2'b00) begin
				pair_idx = 4'(i);
			end
		end
	end

	assign shifted = in_data.value >> {pair_idx, 1'b0};
	assign rot_adj = in_data.rot - pair_idx;
	assign emit    = (in_data.value != '0) || (in_data.opcode == ris_pkg::OP_MOV);
	assign word    = {in_data.condition, ris_pkg::IMM_FORM, in_data.opcode,
		in_data.set_flags, in_data.rn, in_data.rd, rot_adj, shifted[7:0]};

	always_comb begin
		nxt = in_data;
		if (emit) begin
			nxt.words[in_data.count[ris_pkg::IDX_W-1:0]] = word;
			nxt.count = in_data.count + 1'b1;
			nxt.value = shifted >> 8;
			nxt.rot   = rot_adj - 4'd4;
			if (in_data.opcode == ris_pkg::OP_MOV) begin
				nxt.opcode = ris_pkg::OP_ORR;
				nxt.rn     = in_data.reg_number;
			end
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

>>> design/ris_serializer.sv
// ----------------------------------------------------------------------------
// ris_serializer
// Hold the finished words of one item and hand them out one per cycle while word is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ris_serializer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ris_pkg::stage_t in_data,
	ris_word_if.source           word
);

	logic [ris_pkg::CNT_W-1:0]              cnt_q;
	logic [ris_pkg::IDX_W-1:0]              idx_q;
	logic [ris_pkg::MAX_WORDS-1:0][31:0]    words_q;
	logic                                   is_last;
	logic                                   fire;
	logic                                   load;

	assign is_last = ({1'b0, idx_q} + 1'b1) == cnt_q;
	assign fire    = word.valid && word.ready;
	assign in_ready = (cnt_q == '0) || (word.ready && is_last);
	assign load    = in_valid && in_ready;

	assign word.valid     = cnt_q != '0;
	assign word.insn_word = words_q[idx_q];
	assign word.last      = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= in_data.count;
			idx_q <= '0;
		end else if (fire && is_last) begin
			cnt_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= in_data.words;
		end
	end

endmodule

`default_nettype wire

>>> design/rotated_immediate_splitter_top.sv
// ----------------------------------------------------------------------------
// rotated_immediate_splitter_top
// Split a 32-bit constant into ARM data-processing words with rotated
// 8-bit immediates.
// ----------------------------------------------------------------------------
// Each request on cmd carries a condition, S bit, opcode, register and a
// 32-bit constant. The block emits on word one encoded instruction per 8-bit
// chunk of the constant, scanning from the low end and skipping pairs of zero
// bits; last marks the final word of a request. MOV always yields at least one
// word (first operand cleared) and its further words become ORR on the same
// register; TST/TEQ clear the destination; any other opcode with a zero
// constant yields no word at all. Four chunk stages, one per possible word,
// compute all words of a request; a new request may enter every cycle while no
// stage is stalled. The first word leaves the serializer register behind the
// four chunk stage registers. The output then delivers one word per cycle while
// word is ready, one to four per request, and takes a new request only with the
// last word of the old one, so that output register sets the sustained rate.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_immediate_splitter_top (
	input  wire logic clk,
	input  wire logic arst_n,
	ris_cmd_if.sink   cmd,
	ris_word_if.source word
);

	localparam int N = ris_pkg::NUM_STAGES;

	// Stage boundaries: index 0 is the request, index N feeds the serializer
	ris_pkg::stage_t chain_data  [N+1];
	logic            chain_valid [N+1];
	logic            chain_ready [N+1];

	// Seed the pipeline: MOV clears rn, TST/TEQ clear rd, rotate starts at zero
	always_comb begin
		chain_data[0]            = '0;
		chain_data[0].condition  = cmd.condition;
		chain_data[0].set_flags  = cmd.set_flags;
		chain_data[0].opcode     = cmd.opcode;
		chain_data[0].reg_number = cmd.reg_number;
		chain_data[0].rn         = cmd.reg_number;
		chain_data[0].rd         = cmd.reg_number;
		chain_data[0].value      = cmd.immediate;
		if (cmd.opcode == ris_pkg::OP_MOV) begin
			chain_data[0].rn = '0;
		end else if (cmd.opcode == ris_pkg::OP_TST || cmd.opcode == ris_pkg::OP_TEQ) begin
			chain_data[0].rd = '0;
		end
	end

	assign chain_valid[0] = cmd.valid;
	assign cmd.ready      = chain_ready[0];

	// One stage per possible word; each consumes at most one chunk
	for (genvar k = 0; k < N; k++) begin : g_stage
		ris_chunk_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_data   (chain_data[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_data  (chain_data[k+1])
		);
	end

	// Hand out the finished words of one item at a time; drop empty items
	ris_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[N]),
		.in_ready (chain_ready[N]),
		.in_data  (chain_data[N]),
		.word     (word)
	);

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Randomized check of the rotated immediate splitter against its own
// chunking predictor.
// ----------------------------------------------------------------------------
// An initial block fills a queue of split requests: a short directed set
// (extremes, every opcode, zero constants, heavy zero-pair skipping), then
// random requests. A clocked driver sends them with random gaps. A clocked
// monitor stalls the word channel at random. Each accepted request is split
// here into its expected instruction words. The monitor compares every
// accepted word, in order, against the oldest expected word.
// ----------------------------------------------------------------------------

module testbench;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int          TAIL_CYCLES = 24;
	localparam int          MAX_GAP     = 18;
	localparam int          RANDOM_REQS = 447;

	typedef struct {
		logic [3:0]  condition;
		logic        set_flags;
		logic [3:0]  opcode;
		logic [3:0]  reg_number;
		logic [31:0] immediate;
		bit          drain;   // hold this request until all words are out
		bit          quiet;   // no gap after this request
	} split_req_t;

	typedef struct {
		logic [31:0] insn_word;
		logic        last;
	} insn_exp_t;

	logic clk;
	logic arst_n;

	ris_cmd_if  cmd ();
	ris_word_if word ();

	rotated_immediate_splitter_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.word   (word.source)
	);

	split_req_t  pending_reqs[$];
	insn_exp_t   expected_words[$];
	split_req_t  in_flight;
	int unsigned send_gap;
	int unsigned recv_stall;
	bit          recv_quiet;
	int unsigned mismatches;
	int unsigned cycle_count;

	always #6 clk = ~clk;

	// Split one constant into the words the block must emit, oldest first.
	function automatic void split_constant(input split_req_t rq);
		logic [3:0]  op;
		logic [3:0]  rn;
		logic [3:0]  rd;
		logic [3:0]  rot;
		logic [31:0] v;
		int          n;
		insn_exp_t   w;
		op  = rq.opcode;
		rn  = rq.reg_number;
		rd  = rq.reg_number;
		rot = '0;
		v   = rq.immediate;
		n   = 0;
		if (op == ris_pkg::OP_MOV) begin
			rn = '0;
		end else if (op == ris_pkg::OP_TST || op == ris_pkg::OP_TEQ) begin
			rd = '0;
		end
		while ((v != 0 || op == ris_pkg::OP_MOV) && n < ris_pkg::MAX_WORDS) begin
			// skip pairs of zero bits, each pair turns the rotate back by one
			while (v != 0 && v[1:0] == 2'b00) begin
				v   = v >> 2;
				rot = rot - 4'd1;
			end
			w.insn_word = {rq.condition, ris_pkg::IMM_FORM, op, rq.set_flags,
				rn, rd, rot, v[7:0]};
			w.last      = 1'b0;
			expected_words.push_back(w);
			n++;
			// later words of a MOV build on the register with ORR
			if (op == ris_pkg::OP_MOV) begin
				op = ris_pkg::OP_ORR;
				rn = rq.reg_number;
			end
			v   = v >> 8;
			rot = rot - 4'd4;
		end
		if (n > 0)
			expected_words[expected_words.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [31:0] random_constant();
		case ($urandom_range(0, 6))
			0: return $urandom();
			1: return '0;
			2: return 32'($urandom_range(1, 255)) << $urandom_range(0, 24);
			3: return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
			4: return $urandom_range(0, 1) ? 32'hffff_ffff : ~(32'd1 << $urandom_range(0, 31));
			5: return $urandom() & $urandom() & $urandom();
			default: return 32'($urandom_range(1, 3)) << (2 * $urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [3:0] random_opcode();
		if ($urandom_range(0, 1))
			return 4'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
			0: return ris_pkg::OP_MOV;
			1: return ris_pkg::OP_ORR;
			2: return ris_pkg::OP_TST;
			default: return ris_pkg::OP_TEQ;
		endcase
	endfunction

	// Driver: present one request at a time, predict it when taken, then
	// hold valid low for the gap drawn at launch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				split_constant(in_flight);
			if (!cmd.valid || cmd.ready) begin
				if (send_gap > 0) begin
					cmd.valid <= 1'b0;
					send_gap  <= send_gap - 1;
				end else if (pending_reqs.size() == 0) begin
					cmd.valid <= 1'b0;
				end else if (pending_reqs[0].drain && expected_words.size() != 0) begin
					// wait for the word channel to run dry
					cmd.valid <= 1'b0;
				end else begin
					in_flight      <= pending_reqs[0];
					cmd.condition  <= pending_reqs[0].condition;
					cmd.set_flags  <= pending_reqs[0].set_flags;
					cmd.opcode     <= pending_reqs[0].opcode;
					cmd.reg_number <= pending_reqs[0].reg_number;
					cmd.immediate  <= pending_reqs[0].immediate;
					cmd.valid      <= 1'b1;
					send_gap       <= pending_reqs[0].quiet ? 0 : $urandom_range(0, MAX_GAP);
					void'(pending_reqs.pop_front());
				end
			end
		end
	end

	// Monitor: check each taken word against the oldest expectation, then
	// stall ready for a freshly drawn number of cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (word.valid && word.ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: insn_word %08h last %0b", word.insn_word,
						word.last);
					mismatches++;
				end else begin
					if (word.insn_word !== expected_words[0].insn_word) begin
						$error("insn_word: expected %08h, got %08h",
							expected_words[0].insn_word, word.insn_word);
						mismatches++;
					end
					if (word.last !== expected_words[0].last) begin
						$error("last: expected %0b, got %0b", expected_words[0].last,
							word.last);
						mismatches++;
					end
					void'(expected_words.pop_front());
				end
				// switch between stalling and streaming now and then
				if ($urandom_range(0, 49) == 0)
					recv_quiet = !recv_quiet;
				recv_stall = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			word.ready <= (recv_stall == 0);
		end
	end

	// Watchdog: give up at a generous cycle count.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rotated_immediate_splitter_top: mismatch");
			$finish;
		end
	end

	initial begin
		split_req_t rq;
		int         counted;
		bit         quiet_phase;

		clk            = 1'b0;
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.condition  = '0;
		cmd.set_flags  = 1'b0;
		cmd.opcode     = '0;
		cmd.reg_number = '0;
		cmd.immediate  = '0;
		word.ready     = 1'b0;
		send_gap       = 0;
		recv_stall     = 0;
		recv_quiet     = 1'b0;
		mismatches     = 0;
		cycle_count    = 0;
		in_flight      = '{default: '0};

		// Directed: extremes of every field, zero constants, skipping at both ends.
		rq = '{4'h0, 1'b0, ris_pkg::OP_MOV, 4'h0, 32'h0000_0000, 1'b0, 1'b0};
		pending_reqs.push_back(rq);
		rq = '{4'hf, 1'b1, ris_pkg::OP_MOV, 4'hf, 32'hffff_ffff, 1'b0, 1'b1};
		pending_reqs.push_back(rq);
		rq = '{4'h3, 1'b1, ris_pkg::OP_ORR, 4'h7, 32'h0000_0000, 1'b0, 1'b0};
		pending_reqs.push_back(rq);
		rq = '{4'he, 1'b0, ris_pkg::OP_TST, 4'h2, 32'h0000_0000, 1'b0, 1'b0};
		pending_reqs.push_back(rq);
		rq = '{4'h1, 1'b0, ris_pkg::OP_MOV, 4'h5, 32'h0000_0003, 1'b0, 1'b0};
		pending_reqs.push_back(rq);
		rq = '{4'h2, 1'b1, ris_pkg::OP_MOV, 4'ha, 32'hc000_0000, 1'b0, 1'b0};
		pending_reqs.push_back(rq);
		rq = '{4'h7, 1'b0, ris_pkg::OP_TEQ, 4'hc, 32'h8000_0001, 1'b0, 1'b0};
		pending_reqs.push_back(rq);
		// every opcode, with the chunk walking up the constant
		for (int op = 0; op < 16; op++) begin
			rq.condition  = 4'(op);
			rq.set_flags  = op[0];
			rq.opcode     = 4'(op);
			rq.reg_number = 4'(15 - op);
			rq.immediate  = (32'h0000_01a5 << (2 * op)) | (op[1] ? 32'h8000_0000 : 32'h0);
			rq.drain      = (op == 0);
			rq.quiet      = op[2];
			pending_reqs.push_back(rq);
		end

		// Random: phases with and without sender gaps, occasional drains.
		counted     = 0;
		quiet_phase = 1'b0;
		while (counted < RANDOM_REQS) begin
			if ($urandom_range(0, 39) == 0)
				quiet_phase = !quiet_phase;
			rq.condition  = 4'($urandom_range(0, 15));
			rq.set_flags  = 1'($urandom_range(0, 1));
			rq.opcode     = random_opcode();
			rq.reg_number = 4'($urandom_range(0, 15));
			rq.immediate  = random_constant();
			rq.drain      = ($urandom_range(0, 59) == 0);
			rq.quiet      = quiet_phase;
			pending_reqs.push_back(rq);
			counted++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain everything, then let any word-less request clear the pipeline
		while (pending_reqs.size() != 0 || cmd.valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("rotated_immediate_splitter_top: match");
		else
			$display("rotated_immediate_splitter_top: mismatch");
		$finish;
	end

endmodule
